// ===== rtl/core/annexb_nal_access_unit_splitter_assert.svh =====
`ifndef ANNEXB_NAL_ACCESS_UNIT_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_ACCESS_UNIT_SPLITTER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define ANNEXB_ASSERT_IMPLY(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("annexb splitter check failed");

// next-cycle implication, checked while out of reset
`define ANNEXB_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("annexb splitter check failed");

`endif

// ===== rtl/core/annexb_pkg.sv =====
package annexb_pkg;

    localparam logic KIND_NAL = 1'b0;
    localparam logic KIND_AU  = 1'b1;

    localparam logic [4:0] TYPE_SLICE = 5'd1;
    localparam logic [4:0] TYPE_IDR   = 5'd5;
    localparam logic [4:0] TYPE_SPS   = 5'd7;
    localparam logic [4:0] TYPE_PPS   = 5'd8;

    localparam int FM_BITS = 16;
    localparam logic [FM_BITS-1:0] FM_MAX = '1;

    typedef enum logic [1:0] {
        G_IDLE,
        G_ZEROS,
        G_SUFFIX
    } gphase_t;

    typedef enum logic [1:0] {
        GR_PENDING,
        GR_DONE,
        GR_FAIL
    } gres_t;

    function automatic logic is_key_type(input logic [4:0] t);
        return (t == TYPE_SPS) || (t == TYPE_PPS) || (t == TYPE_IDR);
    endfunction

endpackage

// ===== rtl/core/annexb_nal_access_unit_splitter.sv =====
// Annex B NAL and access unit splitter.
// Slave stream: one raw stream byte per word in s_axis_tdata, s_axis_tlast on the
// final byte of a stream. Master stream: one record per word, kind in m_axis_tuser
// (0 NAL record, 1 access unit record), m_axis_tlast on the last record that a byte
// causes. A byte causes zero, one or two records.
// A record leaves on the master side through the input register, then a two-word
// result queue. Throughput: one byte per cycle while the receiver keeps up; a
// byte that causes two records waits until the queue is empty.
// The per-byte work (start code match, eight Exp-Golomb bit steps, counter
// updates) is one combinational pass between the input register and the queue.
// Reset empties the input register and the queue and puts the parser at stream
// start. The final byte of a stream, after emitting its records, resets the parser.
// When the receiver stalls, the queue fills and s_axis_tready drops; no byte or
// record is lost.
module annexb_nal_access_unit_splitter #(
    parameter int LENGTH_BITS      = 24,
    parameter int INDEX_BITS       = 16,
    parameter int MAX_GOLOMB_ZEROS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // data_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // record_index, unit_type, is_key, length_bytes, packet_count, start_packet
    output logic [((3*INDEX_BITS+LENGTH_BITS+6+7)/8)*8-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,  // record_kind
    output logic                   m_axis_tlast
);
    import annexb_pkg::*;

    localparam int DATA_BITS  = 3*INDEX_BITS + LENGTH_BITS + 6;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
    localparam int AW         = MAX_GOLOMB_ZEROS + 1;
    localparam int CW         = $clog2(MAX_GOLOMB_ZEROS + 2);

    typedef struct packed {
        logic                   kind;
        logic [INDEX_BITS-1:0]  index;
        logic [4:0]             unit_type;
        logic                   key;
        logic [LENGTH_BITS-1:0] length;
        logic [INDEX_BITS-1:0]  packets;
        logic [INDEX_BITS-1:0]  first;
        logic                   last;
    } rec_t;

    function automatic logic [INDEX_BITS-1:0] sat_idx(input logic [INDEX_BITS-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] add_len(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [LENGTH_BITS-1:0] b);
        logic [LENGTH_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
    endfunction

    function automatic rec_t au_rec(input logic [INDEX_BITS-1:0]  idx,
                                    input logic [LENGTH_BITS-1:0] len,
                                    input logic [INDEX_BITS-1:0]  pk,
                                    input logic [INDEX_BITS-1:0]  sp);
        rec_t r;
        r           = '0;
        r.kind      = KIND_AU;
        r.index     = idx;
        r.length    = len;
        r.packets   = pk;
        r.first     = sp;
        return r;
    endfunction

    function automatic rec_t nal_rec(input logic [INDEX_BITS-1:0]  idx,
                                     input logic [4:0]             typ,
                                     input logic [LENGTH_BITS-1:0] len);
        rec_t r;
        r           = '0;
        r.kind      = KIND_NAL;
        r.index     = idx;
        r.unit_type = typ;
        r.key       = is_key_type(typ);
        r.length    = len;
        return r;
    endfunction

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    logic [23:0]            recent_reg, recent_next;
    logic [2:0]             pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] nal_len_reg, nal_len_next;
    logic [INDEX_BITS-1:0]  nal_idx_reg, nal_idx_next;
    logic [4:0]             type_reg, type_next;
    logic                   hdr_reg, hdr_next;
    logic [INDEX_BITS-1:0]  au_idx_reg, au_idx_next;
    logic [INDEX_BITS-1:0]  au_pk_reg, au_pk_next;
    logic [LENGTH_BITS-1:0] au_len_reg, au_len_next;
    logic [INDEX_BITS-1:0]  au_first_reg, au_first_next;
    logic [FM_BITS-1:0]     prev_mb_reg, prev_mb_next;
    gphase_t                gph_reg, gph_next;
    logic [CW-1:0]          gcnt_reg, gcnt_next;
    logic [AW-1:0]          gacc_reg, gacc_next;

    // result queue
    rec_t       q_reg [2];
    rec_t       q0_next, q1_next;
    logic [1:0] qcnt_reg, qcnt_next;

    rec_t                   rec0, rec1, nrec;
    logic [1:0]             rec_n;
    logic                   detect;
    logic                   process;
    logic                   pop;
    logic [1:0]             free;
    logic [LENGTH_BITS-1:0] len;
    gres_t                  gres;
    logic [AW-1:0]          gval;
    logic                   gdone;
    logic                   gbit;
    logic [32:0]            v_ext;
    logic [FM_BITS-1:0]     fm;
    logic [INDEX_BITS-1:0]  pk_end;
    logic [LENGTH_BITS-1:0] len_end;

    always_comb
    begin
        recent_next   = recent_reg;
        pos_next      = pos_reg;
        nal_len_next  = nal_len_reg;
        nal_idx_next  = nal_idx_reg;
        type_next     = type_reg;
        hdr_next      = hdr_reg;
        au_idx_next   = au_idx_reg;
        au_pk_next    = au_pk_reg;
        au_len_next   = au_len_reg;
        au_first_next = au_first_reg;
        prev_mb_next  = prev_mb_reg;
        gph_next      = gph_reg;
        gcnt_next     = gcnt_reg;
        gacc_next     = gacc_reg;
        rec0          = '0;
        rec1          = '0;
        nrec          = '0;
        rec_n         = 2'd0;
        len           = '0;
        gres          = GR_PENDING;
        gval          = '0;
        gdone         = 1'b0;
        gbit          = 1'b0;
        v_ext         = '0;
        fm            = '0;
        pk_end        = '0;
        len_end       = '0;

        detect = (recent_reg == 24'd0) && (in_byte_reg == 8'd1)
                 && (pos_reg >= 3'd4) && !in_last_reg;

        if (detect)
        begin
            if (gph_reg != G_IDLE)
            begin
                rec0          = au_rec(au_idx_reg, au_len_reg, au_pk_reg, au_first_reg);
                au_idx_next   = sat_idx(au_idx_reg);
                au_first_next = nal_idx_reg;
                au_pk_next    = '0;
                au_len_next   = '0;
                prev_mb_next  = '0;
                rec_n         = 2'd1;
            end
            len  = (nal_len_reg == '1) ? nal_len_reg : nal_len_reg - LENGTH_BITS'(3);
            nrec = nal_rec(nal_idx_reg, type_reg, len);
            if (rec_n == 2'd0)
            begin
                rec0 = nrec;
            end
            else
            begin
                rec1 = nrec;
            end
            rec_n        = rec_n + 2'd1;
            au_pk_next   = sat_idx(au_pk_next);
            au_len_next  = add_len(au_len_next, len);
            nal_idx_next = sat_idx(nal_idx_reg);
            nal_len_next = LENGTH_BITS'(4);
            type_next    = 5'd0;
            hdr_next     = 1'b1;
            gph_next     = G_IDLE;
            gcnt_next    = '0;
            gacc_next    = '0;
        end
        else
        begin
            nal_len_next = sat_len(nal_len_reg);
            if (hdr_reg && (nal_len_reg == LENGTH_BITS'(4)))
            begin
                type_next = in_byte_reg[4:0];
                hdr_next  = 1'b0;
                if ((nal_idx_reg != '0) && !in_last_reg)
                begin
                    if (in_byte_reg[4:0] == TYPE_SPS)
                    begin
                        rec0          = au_rec(au_idx_reg, au_len_reg, au_pk_reg,
                                               au_first_reg);
                        au_idx_next   = sat_idx(au_idx_reg);
                        au_first_next = nal_idx_reg;
                        au_pk_next    = '0;
                        au_len_next   = '0;
                        rec_n         = 2'd1;
                    end
                    else if (in_byte_reg[4:0] == TYPE_SLICE)
                    begin
                        gph_next  = G_ZEROS;
                        gcnt_next = '0;
                        gacc_next = '0;
                    end
                end
            end
            else if ((gph_reg != G_IDLE) && !in_last_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    gbit = in_byte_reg[3'(7 - i)];
                    if (!gdone)
                    begin
                        case (gph_next)
                            G_ZEROS:
                            begin
                                if (!gbit)
                                begin
                                    gcnt_next = gcnt_next + 1'b1;
                                    if (gcnt_next > CW'(MAX_GOLOMB_ZEROS))
                                    begin
                                        gph_next = G_IDLE;
                                        gres     = GR_FAIL;
                                        gdone    = 1'b1;
                                    end
                                end
                                else if (gcnt_next == '0)
                                begin
                                    gph_next = G_IDLE;
                                    gval     = '0;
                                    gres     = GR_DONE;
                                    gdone    = 1'b1;
                                end
                                else
                                begin
                                    gacc_next = AW'(1);
                                    gph_next  = G_SUFFIX;
                                end
                            end
                            G_SUFFIX:
                            begin
                                gacc_next = {gacc_next[AW-2:0], gbit};
                                gcnt_next = gcnt_next - 1'b1;
                                if (gcnt_next == '0)
                                begin
                                    gph_next = G_IDLE;
                                    gval     = gacc_next - 1'b1;
                                    gres     = GR_DONE;
                                    gdone    = 1'b1;
                                end
                            end
                            default:
                            begin
                                gdone = 1'b1;
                            end
                        endcase
                    end
                end
                if (gres == GR_DONE)
                begin
                    v_ext        = 33'(gval);
                    fm           = (v_ext > 33'(FM_MAX)) ? FM_MAX : v_ext[FM_BITS-1:0];
                    prev_mb_next = fm;
                    if ((gval == '0) || (fm < prev_mb_reg))
                    begin
                        rec0          = au_rec(au_idx_reg, au_len_reg, au_pk_reg,
                                               au_first_reg);
                        au_idx_next   = sat_idx(au_idx_reg);
                        au_first_next = nal_idx_reg;
                        au_pk_next    = '0;
                        au_len_next   = '0;
                        rec_n         = 2'd1;
                    end
                end
                else if (gres == GR_FAIL)
                begin
                    prev_mb_next  = '0;
                    rec0          = au_rec(au_idx_reg, au_len_reg, au_pk_reg, au_first_reg);
                    au_idx_next   = sat_idx(au_idx_reg);
                    au_first_next = nal_idx_reg;
                    au_pk_next    = '0;
                    au_len_next   = '0;
                    rec_n         = 2'd1;
                end
            end
        end

        pos_next    = (pos_reg == 3'd7) ? pos_reg : pos_reg + 3'd1;
        recent_next = {recent_reg[15:0], in_byte_reg};

        // end of stream: close the open NAL and unit, then back to stream start
        if (in_last_reg)
        begin
            len_end       = add_len(au_len_next, nal_len_next);
            pk_end        = sat_idx(au_pk_next);
            rec0          = nal_rec(nal_idx_next, type_next, nal_len_next);
            rec1          = au_rec(au_idx_next, len_end, pk_end, au_first_next);
            rec_n         = 2'd2;
            recent_next   = '1;
            pos_next      = '0;
            nal_len_next  = '0;
            nal_idx_next  = '0;
            type_next     = '0;
            hdr_next      = 1'b1;
            au_idx_next   = '0;
            au_pk_next    = '0;
            au_len_next   = '0;
            au_first_next = '0;
            prev_mb_next  = '0;
            gph_next      = G_IDLE;
            gcnt_next     = '0;
            gacc_next     = '0;
        end

        if (rec_n == 2'd1)
        begin
            rec0.last = 1'b1;
        end
        else if (rec_n == 2'd2)
        begin
            rec1.last = 1'b1;
        end
    end

    assign free          = 2'd2 - qcnt_reg;
    assign process       = in_vld_reg && (rec_n <= free);
    assign s_axis_tready = !in_vld_reg || process;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_axis_tready)
        begin
            in_vld_next = s_axis_tvalid;
        end
    end

    always_comb
    begin
        q0_next   = q_reg[0];
        q1_next   = q_reg[1];
        qcnt_next = qcnt_reg;
        if (pop)
        begin
            q0_next   = q_reg[1];
            qcnt_next = qcnt_next - 2'd1;
        end
        if (process)
        begin
            if (rec_n == 2'd2)
            begin
                q0_next   = rec0;
                q1_next   = rec1;
                qcnt_next = 2'd2;
            end
            else if (rec_n == 2'd1)
            begin
                if (qcnt_next == 2'd0)
                begin
                    q0_next = rec0;
                end
                else
                begin
                    q1_next = rec0;
                end
                qcnt_next = qcnt_next + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            qcnt_reg   <= 2'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            qcnt_reg   <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        q_reg[0] <= q0_next;
        q_reg[1] <= q1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg   <= '1;
            pos_reg      <= '0;
            nal_len_reg  <= '0;
            nal_idx_reg  <= '0;
            type_reg     <= '0;
            hdr_reg      <= 1'b1;
            au_idx_reg   <= '0;
            au_pk_reg    <= '0;
            au_len_reg   <= '0;
            au_first_reg <= '0;
            prev_mb_reg  <= '0;
            gph_reg      <= G_IDLE;
            gcnt_reg     <= '0;
            gacc_reg     <= '0;
        end
        else if (process)
        begin
            recent_reg   <= recent_next;
            pos_reg      <= pos_next;
            nal_len_reg  <= nal_len_next;
            nal_idx_reg  <= nal_idx_next;
            type_reg     <= type_next;
            hdr_reg      <= hdr_next;
            au_idx_reg   <= au_idx_next;
            au_pk_reg    <= au_pk_next;
            au_len_reg   <= au_len_next;
            au_first_reg <= au_first_next;
            prev_mb_reg  <= prev_mb_next;
            gph_reg      <= gph_next;
            gcnt_reg     <= gcnt_next;
            gacc_reg     <= gacc_next;
        end
    end

    assign m_axis_tvalid = (qcnt_reg != 2'd0);
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tlast  = q_reg[0].last;
    assign m_axis_tdata  = TDATA_BITS'({q_reg[0].first, q_reg[0].packets, q_reg[0].length,
                                        q_reg[0].key, q_reg[0].unit_type, q_reg[0].index});

endmodule

// ===== rtl/core/annexb_chk.sv =====
`include "annexb_nal_access_unit_splitter_assert.svh"

module annexb_chk #(
    parameter int LENGTH_BITS = 24,
    parameter int INDEX_BITS  = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    // record_index, unit_type, is_key, length_bytes, packet_count, start_packet
    input logic [((3*INDEX_BITS+LENGTH_BITS+6+7)/8)*8-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,  // record_kind
    input logic                   m_axis_tlast
);
    import annexb_pkg::*;

    localparam int TYPE_LO = INDEX_BITS;
    localparam int KEY_BIT = INDEX_BITS + 5;

    logic [4:0] unit_type;
    logic       key;
    logic       take;

    assign unit_type = m_axis_tdata[TYPE_LO+4:TYPE_LO];
    assign key       = m_axis_tdata[KEY_BIT];
    assign take      = m_axis_tvalid && m_axis_tready;

    // hold a stalled word
    `ANNEXB_ASSERT_NEXT(a_hold_word, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // a unit closed by a start code is followed at once by the finished NAL
    `ANNEXB_ASSERT_NEXT(a_au_then_nal, clk, rst_n,
        take && (m_axis_tuser == KIND_AU) && !m_axis_tlast,
        m_axis_tvalid && (m_axis_tuser == KIND_NAL) && m_axis_tlast)

    // the final NAL is followed at once by the final unit
    `ANNEXB_ASSERT_NEXT(a_nal_then_au, clk, rst_n,
        take && (m_axis_tuser == KIND_NAL) && !m_axis_tlast,
        m_axis_tvalid && (m_axis_tuser == KIND_AU) && m_axis_tlast)

    `ANNEXB_ASSERT_IMPLY(a_key_flag, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_NAL),
        key == is_key_type(unit_type))

endmodule

bind annexb_nal_access_unit_splitter annexb_chk #(
    .LENGTH_BITS(LENGTH_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_annexb_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
